// File: src/vna_pkg.sv
// Shared types, constants and helpers for the vertex normal accumulator.
// Used by every module under src except vna_ram; depends on nothing.
package vna_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int COUNT_BITS_DEF   = 8;

    localparam int IDX_W      = 10;
    localparam int POS_W      = 16;
    localparam int SUM_W      = 24;
    localparam int NRM_W      = 16;
    localparam int FCNT_W     = 8;
    localparam int OPC_W      = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;
    localparam int ONE_Q14    = 16384;

    // shared divider: remainder, dividend shift register, step count
    localparam int DIV_R_W    = 34;
    localparam int DIV_D_W    = 31;
    localparam int DIV_STEP_W = 5;
    localparam int STEP_W     = 5;

    localparam int NDIV_STEPS = 31;
    localparam int RDIV_STEPS = 24;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_POS_RD,
        S_EDGE,
        S_CROSS,
        S_MAG,
        S_NORM,
        S_SQ,
        S_NDIV,
        S_NDIV_WAIT,
        S_SQRT,
        S_NSTORE,
        S_NZERO,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_ADDR,
        S_RD_LATCH,
        S_RDIV,
        S_RDIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD,
        DP_POS_RD,
        DP_EDGE,
        DP_CROSS,
        DP_MAG,
        DP_NORM,
        DP_SQ,
        DP_NDIV,
        DP_SQRT_LD,
        DP_SQRT,
        DP_NSTORE,
        DP_NZERO,
        DP_ACC_RD,
        DP_ACC_WR,
        DP_RSUM_RD,
        DP_RSUM_LD,
        DP_RDIV,
        DP_RRES,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [1:0]        comp;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic degen;
        logic div_done;
        logic out_free;
    } t_stat;

    // index modulo depth by restoring subtraction of shifted depths
    function automatic logic [IDX_W-1:0] vidx_mod(input logic [IDX_W-1:0] v, input int depth);
        logic [26:0] r;
        logic [26:0] d;
        r = 27'(v);
        for (int k = IDX_W - 1; k >= 0; k--) begin
            d = 27'(depth) << k;
            if (r >= d) r = r - d;
        end
        return r[IDX_W-1:0];
    endfunction

endpackage

// File: src/vna_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/vna_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on vna_pkg.
module vna_div import vna_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_R_W-1:0]    i_rem0,
    input  logic [DIV_D_W-1:0]    i_dvd,
    input  logic [DIV_R_W-1:0]    i_dvs,
    input  logic [DIV_STEP_W-1:0] i_steps,
    output logic                  o_done,
    output logic [DIV_D_W-1:0]    o_quot
);

    logic [DIV_R_W-1:0]    r_rem;
    logic [DIV_D_W-1:0]    r_d;
    logic [DIV_D_W-1:0]    r_q;
    logic [DIV_R_W-1:0]    r_dvs;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIV_R_W:0]      trial;
    logic                  ge;

    assign trial = {r_rem, r_d[DIV_D_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_d   <= i_dvd;
            r_dvs <= i_dvs;
            r_q   <= '0;
            r_cnt <= i_steps;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_R_W'(trial - {1'b0, r_dvs}) : trial[DIV_R_W-1:0];
            r_q   <= {r_q[DIV_D_W-2:0], ge};
            r_d   <= r_d << 1;
            r_cnt <= r_cnt - DIV_STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/vna_dp.sv
// Datapath: vertex memories, cross product, normalization, sqrt, accumulate, read.
// Depends on vna_pkg, vna_ram and vna_div.
module vna_dp import vna_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int ACC_W = 3 * SUM_W + COUNT_BITS;
    localparam int MAG_W = 34;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [AW-1:0]              r_vidx [3];
    logic [3*POS_W-1:0]         r_ld;
    logic signed [POS_W-1:0]    r_pa [3];
    logic signed [POS_W-1:0]    r_pb [3];
    logic signed [POS_W:0]      r_e1 [3];
    logic signed [POS_W:0]      r_e2 [3];
    logic signed [2*POS_W+1:0]  r_prod;
    logic signed [2*POS_W+1:0]  r_tmp;
    logic signed [2*POS_W+2:0]  r_cross [3];
    logic [MAG_W-1:0]           r_mag [3];
    logic [2:0]                 r_neg;
    logic [31:0]                r_sq [3];
    logic [DIV_R_W-1:0]         r_s;
    logic [31:0]                r_rq;
    logic [17:0]                r_srem;
    logic [15:0]                r_root;
    logic signed [NRM_W-1:0]    r_n [3];
    logic signed [SUM_W-1:0]    r_rsum [3];
    logic [COUNT_BITS-1:0]      r_rcnt;
    logic signed [NRM_W-1:0]    r_res [3];
    logic                       r_ovalid;
    logic [OUT_DATA_W-1:0]      r_odata;

    logic                pos_we;
    logic [AW-1:0]       pos_raddr;
    logic [3*POS_W-1:0]  pos_rdata;
    logic                acc_we;
    logic [AW-1:0]       acc_waddr;
    logic [AW-1:0]       acc_raddr;
    logic [ACC_W-1:0]    acc_wdata;
    logic [ACC_W-1:0]    acc_rdata;
    logic [ACC_W-1:0]    acc_upd;
    logic [AW-1:0]       corner;

    logic signed [POS_W:0]      ma;
    logic signed [POS_W:0]      mb;
    logic signed [2*POS_W+1:0]  mul_p;
    logic [15:0]                sq_in;
    logic [31:0]                sq_p;

    logic                 any_hi;
    logic                 any_b15;
    logic                 degen;

    logic                  div_start;
    logic [DIV_R_W-1:0]    div_rem0;
    logic [DIV_D_W-1:0]    div_dvd;
    logic [DIV_R_W-1:0]    div_dvs;
    logic [DIV_STEP_W-1:0] div_steps;
    logic                  div_done;
    logic [DIV_D_W-1:0]    div_quot;

    logic [19:0]          sqrt_t;
    logic [17:0]          sqrt_trial;
    logic [16:0]          nrm_c;
    logic [SUM_W-1:0]     rd_mag;
    logic [SUM_W-1:0]     rd_dvd;
    logic [NRM_W-1:0]     rd_q;
    logic [FCNT_W-1:0]    out_cnt;

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [NRM_W-1:0] b);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (t > 25'sd8388607) return 24'sh7FFFFF;
        else if (t < -25'sd8388608) return 24'sh800000;
        return t[SUM_W-1:0];
    endfunction

    always_comb begin
        unique case (i_cmd.comp)
            2'd1:    corner = r_vidx[1];
            2'd2:    corner = r_vidx[2];
            default: corner = r_vidx[0];
        endcase
    end

    // memories
    vna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_waddr(r_vidx[0]),
        .i_wdata(r_ld),
        .i_raddr(pos_raddr),
        .o_rdata(pos_rdata)
    );

    vna_ram #(.WIDTH(ACC_W), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (acc_we),
        .i_waddr(acc_waddr),
        .i_wdata(acc_wdata),
        .i_raddr(acc_raddr),
        .o_rdata(acc_rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_upd[i*SUM_W +: SUM_W] = sat_add(acc_rdata[i*SUM_W +: SUM_W], r_n[i]);
        end
        if (acc_rdata[3*SUM_W +: COUNT_BITS] == CNT_MAX) begin
            acc_upd[3*SUM_W +: COUNT_BITS] = CNT_MAX;
        end else begin
            acc_upd[3*SUM_W +: COUNT_BITS] = acc_rdata[3*SUM_W +: COUNT_BITS]
                                             + COUNT_BITS'(1);
        end
    end

    always_comb begin
        pos_we    = (i_cmd.op == DP_LOAD);
        pos_raddr = (i_cmd.op == DP_POS_RD) ? corner : r_vidx[0];
        acc_we    = 1'b0;
        acc_waddr = r_vidx[0];
        acc_wdata = '0;
        acc_raddr = r_vidx[0];
        priority case (i_cmd.op)
            DP_LOAD:   acc_we = 1'b1;
            DP_ACC_RD: acc_raddr = corner;
            DP_ACC_WR: begin
                acc_we    = 1'b1;
                acc_waddr = corner;
                acc_wdata = acc_upd;
            end
            default: ;
        endcase
    end

    // cross product operands, one product per cycle
    always_comb begin
        unique case (i_cmd.step)
            5'd0:    begin ma = r_e1[1]; mb = r_e2[2]; end
            5'd1:    begin ma = r_e1[2]; mb = r_e2[1]; end
            5'd2:    begin ma = r_e1[2]; mb = r_e2[0]; end
            5'd3:    begin ma = r_e1[0]; mb = r_e2[2]; end
            5'd4:    begin ma = r_e1[0]; mb = r_e2[1]; end
            5'd5:    begin ma = r_e1[1]; mb = r_e2[0]; end
            default: begin ma = r_e1[0]; mb = r_e2[0]; end
        endcase
    end
    assign mul_p = ma * mb;

    always_comb begin
        unique case (i_cmd.step)
            5'd1:    sq_in = r_mag[1][15:0];
            5'd2:    sq_in = r_mag[2][15:0];
            default: sq_in = r_mag[0][15:0];
        endcase
    end
    assign sq_p = sq_in * sq_in;

    assign any_hi  = (|r_mag[0][MAG_W-1:16]) | (|r_mag[1][MAG_W-1:16])
                   | (|r_mag[2][MAG_W-1:16]);
    assign any_b15 = r_mag[0][15] | r_mag[1][15] | r_mag[2][15];
    assign degen   = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);

    // divider setup: face normal ratio or read average
    assign rd_mag = r_rsum[i_cmd.comp][SUM_W-1] ? SUM_W'(-r_rsum[i_cmd.comp])
                                                 : SUM_W'(r_rsum[i_cmd.comp]);
    assign rd_dvd = rd_mag + SUM_W'(r_rcnt >> 1);

    always_comb begin
        div_start = 1'b0;
        div_rem0  = '0;
        div_dvd   = {rd_dvd, (DIV_D_W-SUM_W)'(0)};
        div_dvs   = DIV_R_W'(r_rcnt);
        div_steps = DIV_STEP_W'(RDIV_STEPS);
        priority case (i_cmd.op)
            DP_NDIV: begin
                // dividend is sq * 2^30; first partial remainder stays below s
                div_start = 1'b1;
                div_rem0  = DIV_R_W'(r_sq[i_cmd.comp] >> 1);
                div_dvd   = {r_sq[i_cmd.comp][0], (DIV_D_W-1)'(0)};
                div_dvs   = r_s;
                div_steps = DIV_STEP_W'(NDIV_STEPS);
            end
            DP_RDIV: div_start = 1'b1;
            default: ;
        endcase
    end

    vna_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_rem0 (div_rem0),
        .i_dvd  (div_dvd),
        .i_dvs  (div_dvs),
        .i_steps(div_steps),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // sqrt digit recurrence, two radicand bits per step
    assign sqrt_t     = {r_srem, r_rq[31:30]};
    assign sqrt_trial = {r_root, 2'b01};
    assign nrm_c      = (17'(r_root) + 17'd1) >> 1;
    assign rd_q       = (div_quot[SUM_W-1:0] > SUM_W'(ONE_Q14)) ? NRM_W'(ONE_Q14)
                                                                : div_quot[NRM_W-1:0];

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_CAPTURE: begin
                r_vidx[0] <= AW'(vidx_mod(i_s_tdata[9:0], VERTEX_DEPTH));
                r_vidx[1] <= AW'(vidx_mod(i_s_tdata[19:10], VERTEX_DEPTH));
                r_vidx[2] <= AW'(vidx_mod(i_s_tdata[29:20], VERTEX_DEPTH));
                r_ld      <= i_s_tdata[77:30];
            end
            DP_POS_RD: begin
                for (int i = 0; i < 3; i++) begin
                    if (i_cmd.comp == 2'd1) r_pa[i] <= pos_rdata[i*POS_W +: POS_W];
                    if (i_cmd.comp == 2'd2) r_pb[i] <= pos_rdata[i*POS_W +: POS_W];
                end
            end
            DP_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= (POS_W+1)'(r_pb[i]) - (POS_W+1)'(r_pa[i]);
                    r_e2[i] <= (POS_W+1)'($signed(pos_rdata[i*POS_W +: POS_W]))
                             - (POS_W+1)'(r_pa[i]);
                end
            end
            DP_CROSS: begin
                if (i_cmd.step <= 5'd5) r_prod <= mul_p;
                unique case (i_cmd.step)
                    5'd1, 5'd3, 5'd5: r_tmp <= r_prod;
                    5'd2: r_cross[0] <= (2*POS_W+3)'(r_tmp) - (2*POS_W+3)'(r_prod);
                    5'd4: r_cross[1] <= (2*POS_W+3)'(r_tmp) - (2*POS_W+3)'(r_prod);
                    5'd6: r_cross[2] <= (2*POS_W+3)'(r_tmp) - (2*POS_W+3)'(r_prod);
                    default: ;
                endcase
            end
            DP_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_cross[i][2*POS_W+2];
                    r_mag[i] <= r_cross[i][2*POS_W+2] ? MAG_W'(-r_cross[i])
                                                      : MAG_W'(r_cross[i]);
                end
            end
            DP_NORM: begin
                // largest magnitude is brought into [2^15, 2^16), right shifts truncate
                for (int i = 0; i < 3; i++) begin
                    if (any_hi) r_mag[i] <= r_mag[i] >> 1;
                    else if (!any_b15 && !degen) r_mag[i] <= r_mag[i] << 1;
                end
            end
            DP_SQ: begin
                if (i_cmd.step <= 5'd2) r_sq[i_cmd.step[1:0]] <= sq_p;
                if (i_cmd.step == 5'd0) r_s <= '0;
                else r_s <= r_s + DIV_R_W'(r_sq[i_cmd.step[1:0] - 2'd1]);
            end
            DP_SQRT_LD: begin
                r_rq   <= {1'b0, div_quot};
                r_srem <= '0;
                r_root <= '0;
            end
            DP_SQRT: begin
                r_rq <= r_rq << 2;
                if (sqrt_t >= 20'(sqrt_trial)) begin
                    r_srem <= 18'(sqrt_t - 20'(sqrt_trial));
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_srem <= sqrt_t[17:0];
                    r_root <= {r_root[14:0], 1'b0};
                end
            end
            DP_NSTORE: begin
                r_n[i_cmd.comp] <= r_neg[i_cmd.comp] ? -NRM_W'(nrm_c) : NRM_W'(nrm_c);
            end
            DP_NZERO: begin
                for (int i = 0; i < 3; i++) r_n[i] <= '0;
            end
            DP_RSUM_LD: begin
                for (int i = 0; i < 3; i++) r_rsum[i] <= acc_rdata[i*SUM_W +: SUM_W];
                r_rcnt <= acc_rdata[3*SUM_W +: COUNT_BITS];
            end
            DP_RRES: begin
                if (r_rcnt == '0) r_res[i_cmd.comp] <= '0;
                else if (r_rsum[i_cmd.comp][SUM_W-1]) r_res[i_cmd.comp] <= -rd_q;
                else r_res[i_cmd.comp] <= rd_q;
            end
            default: ;
        endcase
    end

    assign out_cnt = (r_rcnt > 255) ? 8'hFF : FCNT_W'(r_rcnt);

    // output register: next item may start while the result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == DP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_OUT) r_odata <= {out_cnt, r_res[2], r_res[1], r_res[0]};
    end

    assign o_m_tvalid       = r_ovalid;
    assign o_m_tdata        = r_odata;
    assign o_stat.norm_done = !any_hi && any_b15;
    assign o_stat.degen     = degen;
    assign o_stat.div_done  = div_done;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_SQRT_LD) |-> (div_quot <= DIV_D_W'(32'h4000_0000)))
        else $error("normal quotient above 2^30");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_NSTORE) |-> (r_root <= 16'h8000))
        else $error("normal root above 2^15");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ($signed(r_odata[15:0]) <= 16'sd16384
                      && $signed(r_odata[15:0]) >= -16'sd16384))
        else $error("averaged normal out of range");

    a_norm_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_SQ) |-> (!any_hi && any_b15))
        else $error("squares taken before normalization finished");

endmodule

// File: src/vna_ctrl.sv
// Controller state machine: sequences load, triangle and read transactions.
// Depends on vna_pkg.
module vna_ctrl import vna_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic [OPC_W-1:0] i_s_tuser,
    output logic             o_s_tready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    t_state            r_state, n_state;
    logic [1:0]        r_comp, n_comp;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_comp  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_comp     = r_comp;
        n_step     = r_step;
        o_cmd.op   = DP_NOP;
        o_cmd.comp = r_comp;
        o_cmd.step = r_step;
        o_s_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                n_comp = '0;
                n_step = '0;
                if (i_s_tvalid) begin
                    o_cmd.op = DP_CAPTURE;
                    unique case (i_s_tuser)
                        OP_LOAD: n_state = S_LOAD;
                        OP_TRI:  n_state = S_POS_RD;
                        OP_READ: n_state = S_RD_ADDR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.op = DP_LOAD;
                n_state  = S_IDLE;
            end
            S_POS_RD: begin
                o_cmd.op = DP_POS_RD;
                if (r_comp == 2'd2) n_state = S_EDGE;
                else n_comp = r_comp + 2'd1;
            end
            S_EDGE: begin
                o_cmd.op = DP_EDGE;
                n_step   = '0;
                n_state  = S_CROSS;
            end
            S_CROSS: begin
                o_cmd.op = DP_CROSS;
                if (r_step == STEP_W'(6)) n_state = S_MAG;
                else n_step = r_step + STEP_W'(1);
            end
            S_MAG: begin
                o_cmd.op = DP_MAG;
                n_state  = S_NORM;
            end
            S_NORM: begin
                o_cmd.op = DP_NORM;
                n_step   = '0;
                if (i_stat.degen) n_state = S_NZERO;
                else if (i_stat.norm_done) n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = DP_SQ;
                n_comp   = '0;
                if (r_step == STEP_W'(3)) n_state = S_NDIV;
                else n_step = r_step + STEP_W'(1);
            end
            S_NDIV: begin
                o_cmd.op = DP_NDIV;
                n_state  = S_NDIV_WAIT;
            end
            S_NDIV_WAIT: begin
                n_step = '0;
                if (i_stat.div_done) begin
                    o_cmd.op = DP_SQRT_LD;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = DP_SQRT;
                if (r_step == STEP_W'(15)) n_state = S_NSTORE;
                else n_step = r_step + STEP_W'(1);
            end
            S_NSTORE: begin
                o_cmd.op = DP_NSTORE;
                if (r_comp == 2'd2) begin
                    n_comp  = '0;
                    n_state = S_ACC_RD;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_NDIV;
                end
            end
            S_NZERO: begin
                o_cmd.op = DP_NZERO;
                n_comp   = '0;
                n_state  = S_ACC_RD;
            end
            S_ACC_RD: begin
                o_cmd.op = DP_ACC_RD;
                n_state  = S_ACC_WR;
            end
            S_ACC_WR: begin
                // corners go one after another so a repeated corner sees its update
                o_cmd.op = DP_ACC_WR;
                if (r_comp == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_ACC_RD;
                end
            end
            S_RD_ADDR: begin
                o_cmd.op = DP_RSUM_RD;
                n_state  = S_RD_LATCH;
            end
            S_RD_LATCH: begin
                o_cmd.op = DP_RSUM_LD;
                n_comp   = '0;
                n_state  = S_RDIV;
            end
            S_RDIV: begin
                o_cmd.op = DP_RDIV;
                n_state  = S_RDIV_WAIT;
            end
            S_RDIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = DP_RRES;
                    if (r_comp == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = S_RDIV;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && i_s_tvalid) |-> (o_cmd.op == DP_CAPTURE))
        else $error("accepted transaction not captured");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_OUT) |-> i_stat.out_free)
        else $error("result overwritten before taken");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NDIV) |=> (r_state == S_NDIV_WAIT && !i_stat.div_done))
        else $error("divider done too early");

endmodule

// File: src/vertex_normal_accumulator.sv
// Vertex normal accumulator: keeps vertex positions, face normal sums and counts.
// Top level; depends on vna_pkg, vna_ctrl and vna_dp (with vna_ram and vna_div).
//
// Input stream (s side): tuser carries the opcode, tdata the vertex indices and
// position. Load stores a position and clears the vertex sum and count. Triangle
// computes the unit normal of cross(b - a, c - a) in Q1.14 and adds it to the
// three corners. Read returns the averaged normal and the face count on the
// m side. Load and triangle transactions produce no output.
// One transaction is worked on at a time; tready is high only between them.
// Read makes three 24-step passes of the shared restoring divider, one per
// normal component, then loads the output register. Triangle runs a
// normalization shift, then per normal component a 31-step division plus a
// 16-step square root; a degenerate triangle skips the division and root.
// The output register holds one result; the block keeps accepting loads and
// triangles while it waits, and a read stalls only at its end until the
// previous result has been taken. Reset clears control state only; vertex
// memories are undefined until loaded.
module vertex_normal_accumulator import vna_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // opcode
    input  logic [OPC_W-1:0]      i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // normal_x, normal_y, normal_z, face_count
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_cmd  cmd;
    t_stat stat;

    vna_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tuser (i_s_tuser),
        .o_s_tready(o_s_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    vna_dp #(
        .VERTEX_DEPTH(VERTEX_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_s_tdata (i_s_tdata),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tdata (o_m_tdata)
    );

endmodule
